FILE: sv/imf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package imf_pkg;

    // Defaults for the top level parameters
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;
    localparam int PIXEL_BITS_DEF = 8;

    // Register widths
    localparam int WIDTH_REG_BITS  = 11;
    localparam int HEIGHT_REG_BITS = 13;
    localparam int MODE_BITS       = 2;
    localparam int CFG_DATA_BITS   = 13;
    localparam int CFG_INDEX_BITS  = 2;

    localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = WIDTH_REG_BITS'(1024);
    localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = HEIGHT_REG_BITS'(1024);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_WINDOW_MODE  = 2'd2
    } cfg_index_t;

    // Window modes; the unused code behaves as pass through
    localparam logic [MODE_BITS-1:0] MODE_PASS   = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_CROSS  = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_SQUARE = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_RESET  = MODE_SQUARE;

    localparam int WIN_TAPS    = 9;
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic row_end;
        logic frame_end;
        logic last_of_item;
    } res_flags_t;

    // Which of the two possible results of one item are pushed
    typedef struct packed {
        logic first;
        logic second;
    } push_t;

endpackage

`default_nettype wire

FILE: sv/image_median_filter_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// cfg       in         cfg_wr_en            cfg_index, cfg_wdata
// s_*       in         s_tvalid / s_tready  s_tdata pixel_in, s_tuser func
// m_*       out        m_tvalid / m_tready  m_tdata median_out, m_tlast row_end,
//                                           m_tuser {last_of_item, frame_end}
//
// One item per clock while the result queue has room. An item is registered at accept
// together with its line buffer read; the window and median are formed from that
// register, and the results are written into the 4-entry result queue once it has room.
// The line buffer is one RAM port pair (read at accept, write-back at the window stage).
// Items past column 0 push one result, row end items one more: a row of W items gives W
// results, none in the first row. s_tready drops while an item waits on a queue holding
// more than two results. Reset clears counters, window and queue, not the line buffer.

module image_median_filter_core
    import imf_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF,
    localparam int DATA_W    = ((PIXEL_BITS + 7) / 8) * 8
)(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [DATA_W-1:0]         s_tdata,   // pixel_in
    input  logic                      s_tuser,   // func
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [DATA_W-1:0]         m_tdata,   // median_out
    output logic                      m_tlast,   // row_end
    output logic [1:0]                m_tuser    // last_of_item, frame_end
);

    localparam int PB  = PIXEL_BITS;
    localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW  = $clog2(MAX_HEIGHT + 1);
    localparam int WCW = ($clog2(MAX_WIDTH + 1) > WIDTH_REG_BITS) ?
                         $clog2(MAX_WIDTH + 1) : WIDTH_REG_BITS;
    localparam int HCW = (RW > HEIGHT_REG_BITS) ? RW : HEIGHT_REG_BITS;

    // Configuration
    logic [WIDTH_REG_BITS-1:0]  img_width_reg;
    logic [HEIGHT_REG_BITS-1:0] img_height_reg;
    logic [MODE_BITS-1:0]       mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_width_reg  <= WIDTH_RESET;
            img_height_reg <= HEIGHT_RESET;
            mode_reg       <= MODE_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  img_width_reg  <= cfg_wdata[WIDTH_REG_BITS-1:0];
                CFG_IMAGE_HEIGHT: img_height_reg <= cfg_wdata[HEIGHT_REG_BITS-1:0];
                CFG_WINDOW_MODE:  mode_reg       <= cfg_wdata[MODE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Saturated frame size
    logic [WCW-1:0] w_ext, w_sat, w_last;
    logic [HCW-1:0] h_ext, h_sat;

    always_comb
    begin
        w_ext = WCW'(img_width_reg);
        h_ext = HCW'(img_height_reg);
        if (w_ext == '0)
            w_sat = WCW'(1);
        else if (w_ext > WCW'(MAX_WIDTH))
            w_sat = WCW'(MAX_WIDTH);
        else
            w_sat = w_ext;
        if (h_ext == '0)
            h_sat = HCW'(1);
        else if (h_ext > HCW'(MAX_HEIGHT))
            h_sat = HCW'(MAX_HEIGHT);
        else
            h_sat = h_ext;
        w_last = w_sat - WCW'(1);
    end

    // Position counters, advanced at accept
    logic [AW-1:0] col_cnt_reg, col_cnt_next;
    logic [RW-1:0] row_cnt_reg, row_cnt_next;
    logic          row_done0, drain0, in_acc;
    logic          s1_valid_reg, s1_fire, q_room;

    assign row_done0 = (WCW'(col_cnt_reg) >= w_last);
    assign drain0    = (HCW'(row_cnt_reg) >= h_sat);
    assign s1_fire   = s1_valid_reg && q_room;
    assign s_tready  = !s1_valid_reg || s1_fire;
    assign in_acc    = s_tvalid && s_tready;

    always_comb
    begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (in_acc)
        begin
            if (row_done0)
            begin
                col_cnt_next = '0;
                row_cnt_next = drain0 ? '0 : (row_cnt_reg + RW'(1));
            end
            else
            begin
                col_cnt_next = col_cnt_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg  <= '0;
            row_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_cnt_reg  <= col_cnt_next;
            row_cnt_reg  <= row_cnt_next;
            s1_valid_reg <= in_acc || (s1_valid_reg && !s1_fire);
        end
    end

    // Input register
    logic [PB-1:0] s1_pix_reg;
    logic [AW-1:0] s1_col_reg;
    logic          s1_ge1_reg, s1_ge2_reg, s1_row_done_reg, s1_drain_reg;

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_pix_reg      <= s_tuser ? '0 : s_tdata[PB-1:0];
            s1_col_reg      <= col_cnt_reg;
            s1_ge1_reg      <= (row_cnt_reg != '0);
            s1_ge2_reg      <= (row_cnt_reg >= RW'(2));
            s1_row_done_reg <= row_done0;
            s1_drain_reg    <= drain0;
        end
    end

    // Line buffer: {two rows up, one row up} per column
    logic [2*PB-1:0] lb_rd_data;
    logic [PB-1:0]   lb_upper, lb_lower;

    assign lb_upper = lb_rd_data[2*PB-1:PB];
    assign lb_lower = lb_rd_data[PB-1:0];

    imf_line_buf #(
        .DEPTH (MAX_WIDTH),
        .DW    (2 * PB)
    ) u_line_buf (
        .clk     (clk),
        .rd_en   (in_acc),
        .rd_addr (col_cnt_reg),
        .rd_data (lb_rd_data),
        .wr_en   (s1_fire),
        .wr_addr (s1_col_reg),
        .wr_data ({lb_lower, s1_pix_reg})
    );

    // Window: index col*3+row, col 0 left
    logic [PB-1:0] win_reg [WIN_TAPS];
    logic [PB-1:0] win_a   [WIN_TAPS];
    logic [PB-1:0] win_b   [WIN_TAPS];
    logic          first_col;

    assign first_col = (s1_col_reg == '0);

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            win_a[k]     = first_col ? '0 : win_reg[k + 3];
            win_a[k + 3] = first_col ? '0 : win_reg[k + 6];
        end
        win_a[6] = s1_ge2_reg ? lb_upper : '0;
        win_a[7] = s1_ge1_reg ? lb_lower : '0;
        win_a[8] = s1_pix_reg;
        // row tail: one more shift with a zero column
        for (int k = 0; k < 6; k++)
        begin
            win_b[k] = win_a[k + 3];
        end
        for (int k = 6; k < WIN_TAPS; k++)
        begin
            win_b[k] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < WIN_TAPS; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else if (s1_fire)
        begin
            for (int k = 0; k < WIN_TAPS; k++)
            begin
                win_reg[k] <= s1_row_done_reg ? win_b[k] : win_a[k];
            end
        end
    end

    logic [PB-1:0] med_a, med_b;

    imf_median #(.PB(PB)) u_median_a (
        .mode (mode_reg),
        .win  (win_a),
        .med  (med_a)
    );

    imf_median #(.PB(PB)) u_median_b (
        .mode (mode_reg),
        .win  (win_b),
        .med  (med_b)
    );

    push_t      push;
    res_flags_t flags_a, flags_b;

    always_comb
    begin
        push.first             = s1_fire && s1_ge1_reg && !first_col;
        push.second            = s1_fire && s1_ge1_reg && s1_row_done_reg;
        flags_a.row_end        = 1'b0;
        flags_a.frame_end      = 1'b0;
        flags_a.last_of_item   = !s1_row_done_reg;
        flags_b.row_end        = 1'b1;
        flags_b.frame_end      = s1_drain_reg;
        flags_b.last_of_item   = 1'b1;
    end

    imf_out_queue #(
        .PB     (PB),
        .DATA_W (DATA_W)
    ) u_out_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .data0    (med_a),
        .flags0   (flags_a),
        .data1    (med_b),
        .flags1   (flags_b),
        .room     (q_room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

FILE: sv/imf_line_buf.sv
`timescale 1ns / 1ps
`default_nettype none

module imf_line_buf
    import imf_pkg::*;
#(
    parameter int DEPTH = MAX_WIDTH_DEF,
    parameter int DW    = 2 * PIXEL_BITS_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)(
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Same-address write in the same cycle is forwarded (width one rows)
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data <= wr_data;
            end
            else
            begin
                rd_data <= mem[rd_addr];
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/imf_median.sv
`timescale 1ns / 1ps
`default_nettype none

module imf_median
    import imf_pkg::*;
#(
    parameter int PB = PIXEL_BITS_DEF
)(
    input  logic [MODE_BITS-1:0] mode,
    input  logic [PB-1:0]        win [WIN_TAPS],
    output logic [PB-1:0]        med
);

    // returns {max, min}
    function automatic logic [2*PB-1:0] cas(input logic [PB-1:0] a, input logic [PB-1:0] b);
        return (a > b) ? {a, b} : {b, a};
    endfunction

    logic [PB-1:0] p [WIN_TAPS];
    logic [PB-1:0] q [5];
    logic [PB-1:0] med9;
    logic [PB-1:0] med5;

    // 19 compare-exchange median-of-9 network
    always_comb
    begin
        for (int k = 0; k < WIN_TAPS; k++)
        begin
            p[k] = win[k];
        end
        {p[2], p[1]} = cas(p[1], p[2]);
        {p[5], p[4]} = cas(p[4], p[5]);
        {p[8], p[7]} = cas(p[7], p[8]);
        {p[1], p[0]} = cas(p[0], p[1]);
        {p[4], p[3]} = cas(p[3], p[4]);
        {p[7], p[6]} = cas(p[6], p[7]);
        {p[2], p[1]} = cas(p[1], p[2]);
        {p[5], p[4]} = cas(p[4], p[5]);
        {p[8], p[7]} = cas(p[7], p[8]);
        {p[3], p[0]} = cas(p[0], p[3]);
        {p[8], p[5]} = cas(p[5], p[8]);
        {p[7], p[4]} = cas(p[4], p[7]);
        {p[6], p[3]} = cas(p[3], p[6]);
        {p[4], p[1]} = cas(p[1], p[4]);
        {p[5], p[2]} = cas(p[2], p[5]);
        {p[7], p[4]} = cas(p[4], p[7]);
        {p[2], p[4]} = cas(p[4], p[2]);
        {p[4], p[6]} = cas(p[6], p[4]);
        {p[2], p[4]} = cas(p[4], p[2]);
        med9 = p[4];
    end

    // cross: top, left, centre, right, bottom (window index is col*3+row)
    always_comb
    begin
        q[0] = win[3];
        q[1] = win[1];
        q[2] = win[4];
        q[3] = win[7];
        q[4] = win[5];
        {q[1], q[0]} = cas(q[0], q[1]);
        {q[4], q[3]} = cas(q[3], q[4]);
        {q[3], q[0]} = cas(q[0], q[3]);
        {q[4], q[1]} = cas(q[1], q[4]);
        {q[2], q[1]} = cas(q[1], q[2]);
        {q[3], q[2]} = cas(q[2], q[3]);
        {q[2], q[1]} = cas(q[1], q[2]);
        med5 = q[2];
    end

    always_comb
    begin
        case (mode)
            MODE_CROSS:  med = med5;
            MODE_SQUARE: med = med9;
            default:     med = win[4];
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/imf_out_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module imf_out_queue
    import imf_pkg::*;
#(
    parameter int PB     = PIXEL_BITS_DEF,
    parameter int DATA_W = ((PIXEL_BITS_DEF + 7) / 8) * 8
)(
    input  logic              clk,
    input  logic              rst_n,
    input  push_t             push,
    input  logic [PB-1:0]     data0,
    input  res_flags_t        flags0,
    input  logic [PB-1:0]     data1,
    input  res_flags_t        flags1,
    output logic              room,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,
    output logic              m_tlast,
    output logic [1:0]        m_tuser
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = PB + $bits(res_flags_t);

    logic [EW-1:0] entry_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [EW-1:0] e0, e1;
    logic [EW-1:0] head;
    logic [1:0]    n_push;
    logic          pop;
    res_flags_t    head_flags;

    assign e0     = push.first ? {flags0, data0} : {flags1, data1};
    assign e1     = {flags1, data1};
    assign n_push = {1'b0, push.first} + {1'b0, push.second};
    assign pop    = m_tvalid && m_tready;
    // two free slots needed before the next item may finish
    assign room   = (count_reg <= CW'(QUEUE_DEPTH - 2));

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= e0;
        end
        if (n_push == 2'd2)
        begin
            entry_reg[wr_ptr_reg + PW'(1)] <= e1;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(n_push);
        rd_ptr_next = pop ? (rd_ptr_reg + PW'(1)) : rd_ptr_reg;
        count_next  = count_reg + CW'(n_push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head       = entry_reg[rd_ptr_reg];
    assign head_flags = head[EW-1:PB];
    assign m_tvalid   = (count_reg != '0);
    assign m_tdata    = DATA_W'(head[PB-1:0]);
    assign m_tlast    = head_flags.row_end;
    assign m_tuser    = {head_flags.last_of_item, head_flags.frame_end};

endmodule

`default_nettype wire

FILE: sv/imf_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module imf_checker
    import imf_pkg::*;
#(
    parameter int PIXEL_BITS = PIXEL_BITS_DEF,
    localparam int DATA_W    = ((PIXEL_BITS + 7) / 8) * 8
)(
    input logic              clk,
    input logic              rst_n,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata,
    input logic              m_tlast,
    input logic [1:0]        m_tuser
);

    // frame end is only ever flagged on a row tail
    a_frame_end_is_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("frame_end without row_end");

    // the row tail is always the last result of its item
    a_row_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser[1])
        else $error("row_end result not last of item");

    // input only backs up when results are waiting
    a_stall_needs_results: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty result queue");

    a_empty_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !m_tvalid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind image_median_filter_core imf_checker #(.PIXEL_BITS(PIXEL_BITS)) u_imf_checker (.*);

`default_nettype wire
